FILE: src/lzd_pkg.sv
// Shared types and constants for the LZ byte-stream decompressor.
// Depends on nothing; the files that use it refer to it by scoped names.
package lzd_pkg;

    // Default sizes, handed down through the top-level parameters.
    localparam int unsigned HISTORY_DEPTH_DEF = 65536;
    localparam int unsigned QUEUE_DEPTH_DEF   = 4;

    // Address fields in a command are sized for the deepest history allowed.
    localparam int unsigned ADDR_MAX_W = 20;

    localparam logic [7:0] CTRL_COPY_BIT  = 8'h80;
    localparam logic [7:0] CTRL_SHORT_BIT = 8'h40;
    localparam logic [7:0] CTRL_LEN_MASK  = 8'h3f;

    typedef enum logic [1:0] {
        STATUS_DATA     = 2'd0,
        STATUS_BAD_DIST = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_COPY = 2'd1,
        CMD_ERR  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       run_last;
    } out_item_t;

    // One unit of work for the back end.
    typedef struct packed {
        cmd_kind_t             kind;
        logic [7:0]            value;
        status_t               status;
        logic [ADDR_MAX_W-1:0] src;
        logic [ADDR_MAX_W-1:0] dst;
        logic [6:0]            len;
    } cmd_t;

endpackage

FILE: src/lzd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lzd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/lzd_queue.sv
// Small register queue that carries commands from the front end to the back end.
// Depends on nothing; the entry width is set by the instantiating module.
module lzd_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/lzd_front.sv
// Front end: accepts compressed bytes, tracks the parse state and output position,
// checks distance and size, and issues commands for literals, copies and errors. Uses lzd_pkg.
module lzd_front #(
    parameter int unsigned HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  lzd_pkg::in_item_t in_item,
    input  logic [31:0]      output_size,
    output logic             cmd_push,
    output lzd_pkg::cmd_t    cmd,
    input  logic             cmd_full
);

    localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
    localparam int unsigned AW1 = AW + 1;

    typedef enum logic [3:0] {
        PM_CTRL  = 4'b0001,
        PM_LIT   = 4'b0010,
        PM_DLAST = 4'b0100,
        PM_DHIGH = 4'b1000
    } parse_mode_t;

    parse_mode_t parse_mode_reg, parse_mode_next;
    logic [7:0]  lit_left_reg, lit_left_next;
    logic [6:0]  copy_len_reg, copy_len_next;
    logic [7:0]  dist_high_reg, dist_high_next;
    logic [31:0] wpos_reg, wpos_next;
    logic [AW-1:0] wmod_reg, wmod_next;
    logic        halted_reg, halted_next;

    // Working copies after a stream start has been applied.
    parse_mode_t mode_v;
    logic [7:0]  lit_v;
    logic [6:0]  clen_v;
    logic [7:0]  dh_v;
    logic [31:0] wpos_v;
    logic [AW-1:0] wmod_v;
    logic        halt_v;

    logic [7:0]  b;
    logic        accept;
    logic [7:0]  lit_len;
    logic [32:0] lit_end, copy_end;
    logic [16:0] dist_val;
    logic [AW1-1:0] wmod_ext, dist_ext, src_ext, wmod_sum;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_item.data_byte;

    always_comb begin
        mode_v = in_item.stream_start ? PM_CTRL : parse_mode_reg;
        lit_v  = in_item.stream_start ? 8'd0 : lit_left_reg;
        clen_v = in_item.stream_start ? 7'd0 : copy_len_reg;
        dh_v   = in_item.stream_start ? 8'd0 : dist_high_reg;
        wpos_v = in_item.stream_start ? 32'd0 : wpos_reg;
        wmod_v = in_item.stream_start ? '0 : wmod_reg;
        halt_v = in_item.stream_start ? 1'b0 : halted_reg;

        lit_len  = {1'b0, b[6:0]} + 8'd1;
        lit_end  = {1'b0, wpos_v} + 33'(lit_len);
        copy_end = {1'b0, wpos_v} + 33'(clen_v);
        dist_val = {1'b0, dh_v, b} + 17'd1;
        wmod_ext = {1'b0, wmod_v};
        dist_ext = AW1'(dist_val);
        // The history is a ring, so the source wraps around below zero.
        src_ext  = (dist_ext > wmod_ext) ? (wmod_ext + AW1'(HISTORY_DEPTH) - dist_ext)
                                         : (wmod_ext - dist_ext);
        wmod_sum = wmod_ext + AW1'(clen_v);

        parse_mode_next = parse_mode_reg;
        lit_left_next   = lit_left_reg;
        copy_len_next   = copy_len_reg;
        dist_high_next  = dist_high_reg;
        wpos_next       = wpos_reg;
        wmod_next       = wmod_reg;
        halted_next     = halted_reg;

        cmd_push   = 1'b0;
        cmd        = '0;
        cmd.kind   = lzd_pkg::CMD_LIT;
        cmd.status = lzd_pkg::STATUS_DATA;

        if (accept) begin
            parse_mode_next = mode_v;
            lit_left_next   = lit_v;
            copy_len_next   = clen_v;
            dist_high_next  = dh_v;
            wpos_next       = wpos_v;
            wmod_next       = wmod_v;
            halted_next     = halt_v;
            if (!halt_v) begin
                case (mode_v)
                    PM_CTRL: begin
                        if ((b & lzd_pkg::CTRL_COPY_BIT) == 8'd0) begin
                            if (lit_end > {1'b0, output_size}) begin
                                cmd_push      = 1'b1;
                                cmd.kind      = lzd_pkg::CMD_ERR;
                                cmd.status    = lzd_pkg::STATUS_OVERFLOW;
                                halted_next   = 1'b1;
                                lit_left_next = 8'd0;
                                copy_len_next = 7'd0;
                            end else begin
                                lit_left_next   = lit_len;
                                parse_mode_next = PM_LIT;
                            end
                        end else begin
                            copy_len_next  = 7'(b & lzd_pkg::CTRL_LEN_MASK) + 7'd1;
                            dist_high_next = 8'd0;
                            parse_mode_next = ((b & lzd_pkg::CTRL_SHORT_BIT) != 8'd0)
                                              ? PM_DLAST : PM_DHIGH;
                        end
                    end
                    PM_LIT: begin
                        cmd_push      = 1'b1;
                        cmd.kind      = lzd_pkg::CMD_LIT;
                        cmd.value     = b;
                        cmd.dst       = lzd_pkg::ADDR_MAX_W'(wmod_v);
                        wpos_next     = wpos_v + 32'd1;
                        wmod_next     = (wmod_v == AW'(HISTORY_DEPTH - 1)) ? '0
                                        : wmod_v + AW'(1);
                        lit_left_next = lit_v - 8'd1;
                        if (lit_v == 8'd1) begin
                            parse_mode_next = PM_CTRL;
                        end
                    end
                    PM_DHIGH: begin
                        dist_high_next  = b;
                        parse_mode_next = PM_DLAST;
                    end
                    PM_DLAST: begin
                        parse_mode_next = PM_CTRL;
                        cmd_push        = 1'b1;
                        if (32'(dist_val) > wpos_v) begin
                            cmd.kind      = lzd_pkg::CMD_ERR;
                            cmd.status    = lzd_pkg::STATUS_BAD_DIST;
                            halted_next   = 1'b1;
                            lit_left_next = 8'd0;
                            copy_len_next = 7'd0;
                        end else if (copy_end > {1'b0, output_size}) begin
                            cmd.kind      = lzd_pkg::CMD_ERR;
                            cmd.status    = lzd_pkg::STATUS_OVERFLOW;
                            halted_next   = 1'b1;
                            lit_left_next = 8'd0;
                            copy_len_next = 7'd0;
                        end else begin
                            cmd.kind      = lzd_pkg::CMD_COPY;
                            cmd.src       = lzd_pkg::ADDR_MAX_W'(src_ext[AW-1:0]);
                            cmd.dst       = lzd_pkg::ADDR_MAX_W'(wmod_v);
                            cmd.len       = clen_v;
                            wpos_next     = wpos_v + 32'(clen_v);
                            wmod_next     = (wmod_sum >= AW1'(HISTORY_DEPTH))
                                            ? AW'(wmod_sum - AW1'(HISTORY_DEPTH))
                                            : wmod_sum[AW-1:0];
                            copy_len_next = 7'd0;
                        end
                    end
                    default: begin
                        parse_mode_next = PM_CTRL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_mode_reg <= PM_CTRL;
            lit_left_reg   <= 8'd0;
            copy_len_reg   <= 7'd0;
            dist_high_reg  <= 8'd0;
            wpos_reg       <= 32'd0;
            wmod_reg       <= '0;
            halted_reg     <= 1'b0;
        end else begin
            parse_mode_reg <= parse_mode_next;
            lit_left_reg   <= lit_left_next;
            copy_len_reg   <= copy_len_next;
            dist_high_reg  <= dist_high_next;
            wpos_reg       <= wpos_next;
            wmod_reg       <= wmod_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

FILE: src/lzd_back.sv
// Back end: carries out literal, copy and error commands against the history
// memory and drives the registered result stage. Uses lzd_pkg and lzd_ram.
module lzd_back #(
    parameter int unsigned HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lzd_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output lzd_pkg::out_item_t out_item
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_READ = 3'b010,
        BK_EMIT = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [6:0]    left_reg, left_next;
    logic          out_valid_reg, out_valid_next;
    lzd_pkg::out_item_t out_item_reg, out_item_next;

    logic          out_free;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data, rd_data;

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = dst_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (!cmd_empty) begin
                    case (cmd.kind)
                        lzd_pkg::CMD_LIT: begin
                            if (out_free) begin
                                cmd_pop                = 1'b1;
                                wr_en                  = 1'b1;
                                wr_addr                = cmd.dst[AW-1:0];
                                wr_data                = cmd.value;
                                out_valid_next         = 1'b1;
                                out_item_next.out_byte = cmd.value;
                                out_item_next.status   = lzd_pkg::STATUS_DATA;
                                out_item_next.run_last = 1'b1;
                            end
                        end
                        lzd_pkg::CMD_COPY: begin
                            cmd_pop    = 1'b1;
                            src_next   = cmd.src[AW-1:0];
                            dst_next   = cmd.dst[AW-1:0];
                            left_next  = cmd.len;
                            state_next = BK_READ;
                        end
                        lzd_pkg::CMD_ERR: begin
                            if (out_free) begin
                                cmd_pop                = 1'b1;
                                out_valid_next         = 1'b1;
                                out_item_next.out_byte = 8'd0;
                                out_item_next.status   = cmd.status;
                                out_item_next.run_last = 1'b1;
                            end
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ: begin
                rd_en      = 1'b1;
                state_next = BK_EMIT;
            end
            BK_EMIT: begin
                // The byte just written is visible to the next read, which
                // makes overlapping copies come out right.
                if (out_free) begin
                    wr_en                  = 1'b1;
                    out_valid_next         = 1'b1;
                    out_item_next.out_byte = rd_data;
                    out_item_next.status   = lzd_pkg::STATUS_DATA;
                    out_item_next.run_last = (left_reg == 7'd1);
                    src_next  = (src_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : src_reg + AW'(1);
                    dst_next  = (dst_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : dst_reg + AW'(1);
                    left_next = left_reg - 7'd1;
                    state_next = (left_reg == 7'd1) ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    lzd_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (src_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        left_reg     <= left_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: src/lz_byte_stream_decompressor.sv
// LZ byte-stream decompressor, top level. Throughput: one literal byte per cycle
// while neither a held result nor a copy in progress stalls the output; each
// copied byte takes a history read, then an emit and write back through one RAM
// port pair.
// Reset (aresetn low at a clock edge) clears parse state, position, halt flag,
// output_size and all handshakes; the history memory is not cleared.
module lz_byte_stream_decompressor #(
    parameter int unsigned HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned QUEUE_DEPTH   = lzd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Compressed input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  lzd_pkg::in_item_t  s_data,
    // Decompressed result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output lzd_pkg::out_item_t m_data,
    // Configuration channel for the output size register.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    localparam int unsigned CMD_W = $bits(lzd_pkg::cmd_t);

    // The output size register is always writable; the user must change it only while
    // the block is idle (not enforced here), so no transfer in flight mixes old and new.
    logic [31:0] output_size_reg, output_size_next;

    logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
    lzd_pkg::cmd_t front_cmd, head_cmd;
    logic [CMD_W-1:0] head_bits;

    assign cfg_ready        = 1'b1;
    assign output_size_next = (cfg_valid && cfg_ready) ? cfg_data : output_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_size_reg <= 32'd0;
        end else begin
            output_size_reg <= output_size_next;
        end
    end

    // The front end parses one byte per cycle and stalls only when the
    // command queue is full.
    lzd_front #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_item     (s_data),
        .output_size (output_size_reg),
        .cmd_push    (cmd_push),
        .cmd         (front_cmd),
        .cmd_full    (cmd_full)
    );

    // The queue decouples parsing from the byte-at-a-time copy engine.
    lzd_queue #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (front_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .head      (head_bits),
        .empty     (cmd_empty)
    );

    assign head_cmd = lzd_pkg::cmd_t'(head_bits);

    // The back end owns the history memory and the result register, so a
    // waiting result holds the front end back only once the queue has filled.
    lzd_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (head_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lz_byte_stream_decompressor.
// Needs lzd_pkg and the top module; drives directed and random compressed
// streams and compares every output byte with an in-bench decoder.
module tb;

    localparam int unsigned HIST_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF;

    typedef enum logic [1:0] {
        MODE_CONTROL   = 2'd0,
        MODE_LITERAL   = 2'd1,
        MODE_DIST_LAST = 2'd2,
        MODE_DIST_HIGH = 2'd3
    } parse_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    lzd_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    lzd_pkg::out_item_t m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [31:0]        cfg_data = '0;

    lz_byte_stream_decompressor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Decoder state, a private copy of what the block should hold.
    logic [31:0]  size_limit = '0;
    parse_mode_t  parse_mode = MODE_CONTROL;
    logic [7:0]   lits_left = '0;
    logic [6:0]   copy_len = '0;
    logic [7:0]   dist_high = '0;
    logic [31:0]  write_pos = '0;
    logic         stream_halted = 1'b0;
    logic [7:0]   history_mem [HIST_DEPTH];

    lzd_pkg::out_item_t predicted_out[$];
    lzd_pkg::in_item_t  pending_items[$];
    lzd_pkg::out_item_t want_item;

    int unsigned live_items = 0;   // transfers that the block does not ignore
    int unsigned mismatches = 0;
    logic        calm = 1'b0;      // when set, neither side inserts gaps

    // Stream planning state: where the generator believes the output is.
    int unsigned gen_pos = 0;
    logic        start_next = 1'b0;

    function automatic bit fits_output(input int unsigned count);
        return ({1'b0, write_pos} + 33'(count)) <= {1'b0, size_limit};
    endfunction

    task automatic predict_fault(input lzd_pkg::status_t code);
        lzd_pkg::out_item_t r;
        stream_halted = 1'b1;
        parse_mode = MODE_CONTROL;
        lits_left = '0;
        copy_len = '0;
        r.out_byte = 8'h00;
        r.status = code;
        r.run_last = 1'b1;
        predicted_out.push_back(r);
    endtask

    // Works out the results that one accepted compressed byte causes.
    task automatic decode_item(input lzd_pkg::in_item_t item);
        logic [7:0]         b;
        logic [31:0]        distance;
        logic [7:0]         v;
        int                 k;
        lzd_pkg::out_item_t r;
        b = item.data_byte;
        if (item.stream_start) begin
            write_pos = '0;
            parse_mode = MODE_CONTROL;
            lits_left = '0;
            copy_len = '0;
            dist_high = '0;
            stream_halted = 1'b0;
        end
        if (!stream_halted) begin
            live_items++;
            case (parse_mode)
                MODE_CONTROL: begin
                    if ((b & lzd_pkg::CTRL_COPY_BIT) == 8'h00) begin
                        // Literal run: the whole run is checked against the size up front.
                        if (fits_output(int'(b) + 1)) begin
                            lits_left = b + 8'd1;
                            parse_mode = MODE_LITERAL;
                        end else begin
                            predict_fault(lzd_pkg::STATUS_OVERFLOW);
                        end
                    end else begin
                        copy_len = 7'((b & lzd_pkg::CTRL_LEN_MASK) + 8'd1);
                        dist_high = '0;
                        parse_mode = ((b & lzd_pkg::CTRL_SHORT_BIT) != 8'h00) ?
                                     MODE_DIST_LAST : MODE_DIST_HIGH;
                    end
                end
                MODE_LITERAL: begin
                    history_mem[write_pos % HIST_DEPTH] = b;
                    write_pos++;
                    lits_left--;
                    if (lits_left == 8'd0) begin
                        parse_mode = MODE_CONTROL;
                    end
                    r.out_byte = b;
                    r.status = lzd_pkg::STATUS_DATA;
                    r.run_last = 1'b1;
                    predicted_out.push_back(r);
                end
                MODE_DIST_HIGH: begin
                    dist_high = b;
                    parse_mode = MODE_DIST_LAST;
                end
                default: begin
                    distance = {16'h0000, dist_high, b} + 32'd1;
                    parse_mode = MODE_CONTROL;
                    if (distance > write_pos) begin
                        predict_fault(lzd_pkg::STATUS_BAD_DIST);
                    end else if (!fits_output(int'(copy_len))) begin
                        predict_fault(lzd_pkg::STATUS_OVERFLOW);
                    end else begin
                        // Byte by byte, so an overlapping copy repeats its own output.
                        for (k = 0; k < int'(copy_len); k++) begin
                            v = history_mem[(write_pos - distance) % HIST_DEPTH];
                            history_mem[write_pos % HIST_DEPTH] = v;
                            write_pos++;
                            r.out_byte = v;
                            r.status = lzd_pkg::STATUS_DATA;
                            r.run_last = (k + 1 == int'(copy_len));
                            predicted_out.push_back(r);
                        end
                        copy_len = '0;
                    end
                end
            endcase
        end
    endtask

    // Input driver: one nonblocking update of valid per edge, payload held while stalled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_item(s_data);
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: every transfer is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with none predicted: byte %02h status %0d last %0b",
                                 $realtime, m_data.out_byte, m_data.status, m_data.run_last);
                    end
                end else begin
                    want_item = predicted_out.pop_front();
                    if (m_data.out_byte !== want_item.out_byte ||
                        m_data.status !== want_item.status ||
                        m_data.run_last !== want_item.run_last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: byte %02h/%02h status %0d/%0d last %0b/%0b (exp/got)",
                                     $realtime, want_item.out_byte, m_data.out_byte,
                                     want_item.status, m_data.status,
                                     want_item.run_last, m_data.run_last);
                        end
                    end
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // A set start_next marks the next queued byte as the first of a stream.
    task automatic push_item(input logic [7:0] b, input logic st);
        lzd_pkg::in_item_t it;
        it.data_byte = b;
        it.stream_start = st | start_next;
        start_next = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic restart_plan();
        start_next = 1'b1;
        gen_pos = 0;
    endtask

    // Queues one piece of a stream: mostly well-formed runs and references,
    // with some noise and some sequences cut off by a new stream.
    task automatic plan_random_unit(input int unsigned restart_pct);
        int unsigned pick;
        int unsigned n;
        int unsigned len;
        int unsigned lim;
        int unsigned distance;
        logic [15:0] code;
        logic        short_form;
        if ($urandom_range(99) < restart_pct) begin
            restart_plan();
        end
        pick = $urandom_range(99);
        if (pick < 6) begin
            n = $urandom_range(3, 1);
            repeat (n) push_item(8'($urandom_range(255)), $urandom_range(7) == 0);
            restart_plan();
        end else if (pick < 11) begin
            if ($urandom_range(1) == 1) begin
                n = $urandom_range(20, 2);
                push_item(8'(n - 1), 1'b0);
                repeat ($urandom_range(n - 1)) push_item(8'($urandom_range(255)), 1'b0);
            end else begin
                push_item(8'($urandom_range(255)) | lzd_pkg::CTRL_COPY_BIT, 1'b0);
                if ($urandom_range(1) == 1) begin
                    push_item(8'($urandom_range(255)), 1'b0);
                end
            end
            restart_plan();
        end else if (pick < 55 || gen_pos == 0) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
            push_item(8'(n), 1'b0);
            repeat (n + 1) push_item(8'($urandom_range(255)), 1'b0);
            gen_pos += n + 1;
        end else begin
            len = ($urandom_range(7) == 0) ? 64 : $urandom_range(12, 1);
            lim = (gen_pos > HIST_DEPTH) ? HIST_DEPTH : gen_pos;
            if ($urandom_range(19) == 0 && lim < HIST_DEPTH) begin
                // Reaches just before the start of the stream.
                distance = lim + $urandom_range(3, 1);
                if (distance > HIST_DEPTH) begin
                    distance = HIST_DEPTH;
                end
            end else if ($urandom_range(1) == 1) begin
                distance = $urandom_range((lim < 8) ? lim : 8, 1);
            end else begin
                distance = $urandom_range(lim, 1);
            end
            code = 16'(distance - 1);
            short_form = (code <= 16'd255) && ($urandom_range(1) == 1);
            push_item({1'b1, short_form, 6'(len - 1)}, 1'b0);
            if (!short_form) begin
                push_item(code[15:8], 1'b0);
            end
            push_item(code[7:0], 1'b0);
            gen_pos += len;
        end
    endtask

    task automatic run_random(input int unsigned target, input int unsigned restart_pct);
        int unsigned base;
        base = live_items;
        restart_plan();
        while (live_items - base < target) begin
            repeat (2) plan_random_unit(restart_pct);
            while (pending_items.size() != 0) @(posedge aclk);
        end
    endtask

    // Holds the sender until the block has drained, then leaves room for
    // a byte that produces nothing to finish inside the block.
    task automatic settle();
        while (pending_items.size() != 0 || s_valid || predicted_out.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_output_size(input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_limit = value;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With no room at all, a literal run faults at once and the rest is ignored.
        write_output_size(32'h0000_0000);
        push_item(8'h00, 1'b1);
        push_item(8'h41, 1'b0);
        settle();

        // Room for five bytes: four literals fit, a two-byte copy then overflows.
        write_output_size(32'd5);
        push_item(8'h03, 1'b1);
        push_item(8'h11, 1'b0);
        push_item(8'h22, 1'b0);
        push_item(8'h33, 1'b0);
        push_item(8'h44, 1'b0);
        push_item(8'hC1, 1'b0);
        push_item(8'h00, 1'b0);
        settle();

        write_output_size(32'hFFFF_FFFF);
        // Literal run with extreme byte values.
        push_item(8'h02, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h5A, 1'b0);
        // Short reference of one byte at distance one.
        push_item(8'hC0, 1'b0);
        push_item(8'h00, 1'b0);
        // Longest reference, overlapping itself at distance three.
        push_item(8'hFF, 1'b0);
        push_item(8'h02, 1'b0);
        // Long-form reference.
        push_item(8'h80, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h03, 1'b0);
        // Distance past the stream start; the next byte is ignored while halted.
        push_item(8'hC0, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h7F, 1'b0);
        // New stream with the largest distance, again before the start.
        push_item(8'hBF, 1'b1);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b0);
        // A new stream that cuts a literal run short.
        push_item(8'h01, 1'b1);
        push_item(8'hAA, 1'b0);
        push_item(8'h00, 1'b1);
        push_item(8'h55, 1'b0);
        settle();

        run_random(80, 3);
        settle();

        // Small output sizes make overflow a common outcome.
        write_output_size(32'($urandom_range(200, 8)));
        run_random(45, 25);
        settle();

        // A stretch with no gaps on either side.
        write_output_size($urandom);
        calm <= 1'b1;
        run_random(60, 3);
        settle();
        calm <= 1'b0;

        write_output_size(32'h0000_0000);
        run_random(10, 30);
        settle();

        write_output_size(32'hFFFF_FFFF);
        run_random(60, 3);
        settle();

        if (mismatches == 0 && predicted_out.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
